/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the delay quantizer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk_i, rst_i, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk_i, rst_i, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

/* sv/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// Delay quantizer package
// Sequencer states, register indexes, table generator and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int ENTRY_W = 14;
  localparam int CFG_W = 15;
  localparam int LEVEL_W = 8;

  localparam logic [CFG_W-1:0] TIMEOUT_RESET = 15'd3000;
  localparam logic [CFG_W-1:0] GLITCH_RESET = 15'd80;
  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RESET = 8'd5;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

  localparam longint unsigned ONE_Q31 = 64'd1 << 31;
  localparam longint unsigned LN2_Q31 = 64'd1488522236;

  typedef enum logic [1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_GLITCH    = 2'd1,
    CFG_MIN_LEVEL = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_GLITCH,
    S_SEARCH,
    S_PICK,
    S_OUT
  } state_t;

  // Table entry i: 11675 * i^-0.9161 in fixed point, evaluated at elaboration.
  function automatic logic [ENTRY_W-1:0] rom_entry(input int unsigned idx);
    longint unsigned v;
    longint unsigned m;
    longint unsigned frac;
    longint unsigned lg;
    longint unsigned y;
    longint unsigned yi;
    longint unsigned z;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned e;
    longint unsigned r;
    int unsigned n;
    int unsigned s;
    int unsigned k;
    v = 64'(idx);
    n = 0;
    for (s = 1; s < 63; s++) begin
      if ((v >> s) != 64'd0) n = s;
    end
    m = (v << 30) >> n;
    frac = 64'd0;
    for (s = 0; s < 31; s++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    lg = (64'(n) << 31) | frac;
    y = (lg * 64'd9161) / 64'd10000;
    yi = y >> 31;
    z = ((y & (ONE_Q31 - 64'd1)) * LN2_Q31) >> 31;
    term = ONE_Q31;
    pos = ONE_Q31;
    neg = 64'd0;
    for (k = 1; k <= 24; k++) begin
      term = ((term * z) >> 31) / 64'(k);
      if (k[0]) neg = neg + term;
      else pos = pos + term;
    end
    e = (pos > neg) ? pos - neg : 64'd0;
    r = (64'd11675 * e) >> (64'd31 + yi);
    return ENTRY_W'(r);
  endfunction

  // Quotient by 1023 for values below 2^18: one correction step suffices.
  function automatic logic [7:0] div1023(input logic [17:0] x);
    logic [7:0] q0;
    logic [10:0] r;
    q0 = x[17:10];
    r = {1'b0, x[9:0]} + {3'b000, q0};
    return (r >= 11'd1023) ? q0 + 8'd1 : q0;
  endfunction

endpackage

`default_nettype wire

/* sv/clock_sync_delay_quantizer_unit.sv */
// ----------------------------------------------------------------------------
// Clock-synchronised delay quantizer
// Tracks the external clock period and turns it, or the knob, into a level.
// ----------------------------------------------------------------------------
// Each input word updates the tick counter and period history at once and
// yields one output word. In free mode a word goes from the setup state
// straight to the output state. In sync mode the averaged period is divided
// one bit per cycle and, above the glitch limit, the table is then searched
// one entry per cycle, both through a single shared subtractor, before the
// word reaches the output register; the next word can be taken in the cycle
// after that. A new word is taken only in the idle state, while an earlier
// result may still wait in the output register; a finished word stalls until
// the output register is free.
`default_nettype none

`include "assert_macros.svh"

module clock_sync_delay_quantizer_unit
  import cdq_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int COUNT_WIDTH = 15
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                tick,
  input  wire logic                clock_level,
  input  wire logic [9:0]          knob_a,
  input  wire logic [9:0]          knob_b,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [LEVEL_W-1:0]       drive_level,
  output logic                     free_mode,
  output logic                     led,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  localparam int JW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (COUNT_WIDTH + 1 > 16) ? COUNT_WIDTH + 1 : 16;
  localparam int CMPW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam int LW = (JW > LEVEL_W) ? JW : LEVEL_W;
  localparam int DCW = $clog2(COUNT_WIDTH + 1);
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]       sync_timeout_ms;
  logic [CFG_W-1:0]       glitch_limit;
  logic [LEVEL_W-1:0]     min_level;

  logic [COUNT_WIDTH-1:0] tick_counter;
  logic [COUNT_WIDTH-1:0] last_period;
  logic [COUNT_WIDTH-1:0] older_period;
  logic                   previous_level;

  logic [9:0]             knob_sum;
  logic                   led_hold;
  logic [2:0]             divisor;
  logic [2:0]             rem;
  logic [COUNT_WIDTH-1:0] dq;
  logic [DCW-1:0]         div_cnt;
  logic [JW-1:0]          j_idx;
  logic [ENTRY_W-1:0]     prev_entry;
  logic [ENTRY_W-1:0]     cur_entry;
  logic                   prev_inf;
  logic [LEVEL_W-1:0]     level;
  logic                   free_flag;

  logic                   accept;
  logic                   out_free;
  logic [10:0]            knob_total;
  logic [9:0]             knob_clip;
  logic [COUNT_WIDTH-1:0] cnt_ticked;
  logic                   rise;
  logic [12:0]            k5;
  logic [17:0]            k254;
  logic [LEVEL_W-1:0]     free_lvl;
  logic [2:0]             div_sel;
  logic [COUNT_WIDTH:0]   period_sum;
  logic                   timeout_hit;
  logic [ENTRY_W:0]       entry_pair;
  logic [ENTRY_W-1:0]     rom_data;
  logic [AW-1:0]          alu_a;
  logic [AW-1:0]          alu_b;
  logic [AW-1:0]          alu_diff;
  logic                   alu_borrow;
  logic [JW-1:0]          pick_idx;
  logic [LW-1:0]          pick_ext;
  logic [LEVEL_W-1:0]     clamped;

  cdq_alu #(
    .W(AW)
  ) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  cdq_rom #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_rom (
    .index (j_idx),
    .entry (rom_data)
  );

  assign accept = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign knob_total = {1'b0, knob_a} + {1'b0, knob_b};
  assign knob_clip = knob_total[10] ? 10'h3FF : knob_total[9:0];
  assign cnt_ticked = (tick && tick_counter != CntMax) ? tick_counter + COUNT_WIDTH'(1) :
                      tick_counter;
  assign rise = !previous_level && clock_level;

  assign k5 = {1'b0, knob_sum, 2'b00} + {3'b000, knob_sum};
  assign k254 = {knob_sum, 8'h00} - {7'b0000000, knob_sum, 1'b0};
  assign free_lvl = div1023(k254) + 8'd1;
  assign div_sel = 3'(div1023(18'(k5))) + 3'd1;
  assign period_sum = {1'b0, last_period} + {1'b0, older_period};
  assign timeout_hit = CMPW'(tick_counter) >= CMPW'(sync_timeout_ms);
  assign entry_pair = {1'b0, prev_entry} + {1'b0, cur_entry};

  always_comb begin
    if (prev_inf) pick_idx = '0;
    else if (alu_borrow) pick_idx = j_idx - JW'(1);
    else pick_idx = j_idx;
    pick_ext = LW'(pick_idx);
    if (pick_ext < LW'(min_level)) clamped = min_level;
    else if (pick_ext > LW'(LEVEL_MAX)) clamped = LEVEL_MAX;
    else clamped = pick_ext[LEVEL_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_SETUP;
      end
      S_SETUP: begin
        state_next = timeout_hit ? S_OUT : S_DIV;
      end
      S_DIV: begin
        if (div_cnt == DCW'(1)) state_next = S_GLITCH;
      end
      S_GLITCH: begin
        state_next = alu_borrow ? S_SEARCH : S_OUT;
      end
      S_SEARCH: begin
        if (!alu_borrow) state_next = S_PICK;
      end
      S_PICK: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    alu_a = '0;
    alu_b = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_DIV: begin
        alu_a = AW'({rem, dq[COUNT_WIDTH-1]});
        alu_b = AW'(divisor);
      end
      S_GLITCH: begin
        alu_a = AW'(glitch_limit);
        alu_b = AW'(dq);
      end
      S_SEARCH: begin
        alu_a = AW'(dq);
        alu_b = AW'(rom_data);
      end
      S_PICK: begin
        alu_a = AW'({dq, 1'b0});
        alu_b = AW'(entry_pair);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      sync_timeout_ms <= TIMEOUT_RESET;
      glitch_limit <= GLITCH_RESET;
      min_level <= MIN_LEVEL_RESET;
      tick_counter <= '0;
      last_period <= '0;
      older_period <= '0;
      previous_level <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_TIMEOUT:   sync_timeout_ms <= cfg_data;
          CFG_GLITCH:    glitch_limit <= cfg_data;
          CFG_MIN_LEVEL: min_level <= cfg_data[LEVEL_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        previous_level <= clock_level;
        if (rise) begin
          older_period <= last_period;
          last_period <= cnt_ticked;
          tick_counter <= '0;
        end else begin
          tick_counter <= cnt_ticked;
        end
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_OUT && out_free) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      knob_sum <= knob_clip;
      led_hold <= clock_level;
    end
    case (state)
      S_SETUP: begin
        if (timeout_hit) begin
          level <= free_lvl;
          free_flag <= 1'b1;
        end else begin
          free_flag <= 1'b0;
          divisor <= div_sel;
          rem <= '0;
          dq <= period_sum[COUNT_WIDTH:1];
          div_cnt <= DCW'(COUNT_WIDTH);
        end
      end
      S_DIV: begin
        if (alu_borrow) rem <= {rem[1:0], dq[COUNT_WIDTH-1]};
        else rem <= alu_diff[2:0];
        dq <= {dq[COUNT_WIDTH-2:0], !alu_borrow};
        div_cnt <= div_cnt - DCW'(1);
      end
      S_GLITCH: begin
        if (alu_borrow) begin
          j_idx <= JW'(1);
          prev_inf <= 1'b1;
        end else begin
          level <= LEVEL_MAX;
        end
      end
      S_SEARCH: begin
        if (!alu_borrow) begin
          cur_entry <= rom_data;
        end else begin
          prev_entry <= rom_data;
          prev_inf <= 1'b0;
          j_idx <= j_idx + JW'(1);
        end
      end
      S_PICK: begin
        level <= clamped;
      end
      S_OUT: begin
        if (out_free) begin
          drive_level <= level;
          free_mode <= free_flag;
          led <= led_hold;
        end
      end
      default: begin
      end
    endcase
  end

  `ASSERT_IMPL(a_out_from_seq, clk, rst, $rose(out_valid), $past(state == S_OUT))
  `ASSERT_NEXT(a_accept_setup, clk, rst, accept, state == S_SETUP)
  `ASSERT_IMPL(a_search_range, clk, rst, state == S_SEARCH, (j_idx >= JW'(1)) && (j_idx <= JW'(TABLE_DEPTH)))
  `ASSERT_IMPL(a_pick_below, clk, rst, state == S_PICK, AW'(cur_entry) <= AW'(dq))

endmodule

`default_nettype wire

/* sv/cdq_alu.sv */
// ----------------------------------------------------------------------------
// Shared subtractor
// The shared subtractor of the quantizer: difference and borrow of a - b.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_alu #(
  parameter int W = 16
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] diff,
  output logic              borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

`default_nettype wire

/* sv/cdq_rom.sv */
// ----------------------------------------------------------------------------
// Level table
// Constant decreasing table; entry 0 is the maximum and the entry past the
// last reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_rom
  import cdq_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] index,
  output logic      [ENTRY_W-1:0]               entry
);

  logic [ENTRY_W-1:0] tab [TABLE_DEPTH+1];

  for (genvar g = 0; g <= TABLE_DEPTH; g++) begin : g_tab
    if (g == 0) begin : g_top
      assign tab[g] = '1;
    end else if (g == TABLE_DEPTH) begin : g_end
      assign tab[g] = '0;
    end else begin : g_val
      localparam logic [ENTRY_W-1:0] Val = rom_entry(g);
      assign tab[g] = Val;
    end
  end

  assign entry = (index <= ($clog2(TABLE_DEPTH+1))'(TABLE_DEPTH)) ? tab[index] : '0;

endmodule

`default_nettype wire

/* dv/clock_sync_delay_quantizer_unit_test.sv */
// ----------------------------------------------------------------------------
// Delay quantizer unit test
// Drives tick, clock and knob words into the quantizer and checks every
// output word against a cycle-free model of the period tracker, the divider
// and the nearest-entry table search, across several register settings.
// ----------------------------------------------------------------------------
module clock_sync_delay_quantizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  localparam int unsigned RUN_LIMIT = 4000000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned COUNT_LIMIT = 32767;
  localparam int unsigned PHASE_WORDS = 330;
  localparam longint unsigned Q31_ONE = 64'd1 << 31;
  localparam longint unsigned Q31_LN2 = 64'd1488522236;

  typedef struct packed {
    logic [7:0] level;
    logic       free_flag;
    logic       led;
  } quant_word_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               tick = 1'b0;
  logic               clock_level = 1'b0;
  logic [9:0]         knob_a = '0;
  logic [9:0]         knob_b = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [LEVEL_W-1:0] drive_level;
  logic               free_mode;
  logic               led;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = CFG_TIMEOUT;
  logic [CFG_W-1:0]   cfg_data = '0;

  longint unsigned decay_table [0:256];
  int unsigned timeout_ms;
  int unsigned glitch_lim;
  int unsigned level_floor;
  int unsigned tick_count;
  int unsigned period_new;
  int unsigned period_old;
  logic        clock_prev;

  quant_word_t expected_q[$];
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned cycle_count;

  clock_sync_delay_quantizer_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .tick        (tick),
    .clock_level (clock_level),
    .knob_a      (knob_a),
    .knob_b      (knob_b),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive_level (drive_level),
    .free_mode   (free_mode),
    .led         (led),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Entry of the decreasing table: 11675 * 2^(-0.9161 * log2(pos)) as an integer, computed in Q31.
  function automatic longint unsigned decay_entry(input int unsigned pos);
    longint unsigned v;
    longint unsigned mant;
    longint unsigned lg_frac;
    longint unsigned lg;
    longint unsigned expo;
    longint unsigned expo_int;
    longint unsigned zarg;
    longint unsigned term;
    longint unsigned even_sum;
    longint unsigned odd_sum;
    longint unsigned ex;
    int unsigned msb;
    int unsigned k;
    v = 64'(pos);
    msb = 0;
    while (msb < 62 && (v >> (msb + 1)) != 64'd0) msb++;
    mant = (v << 30) >> msb;
    lg_frac = 64'd0;
    repeat (31) begin
      mant = (mant * mant) >> 30;
      lg_frac = lg_frac << 1;
      if (mant >= Q31_ONE) begin
        mant = mant >> 1;
        lg_frac = lg_frac | 64'd1;
      end
    end
    lg = (64'(msb) << 31) | lg_frac;
    expo = (lg * 64'd9161) / 64'd10000;
    expo_int = expo >> 31;
    zarg = ((expo & (Q31_ONE - 64'd1)) * Q31_LN2) >> 31;
    term = Q31_ONE;
    even_sum = Q31_ONE;
    odd_sum = 64'd0;
    for (k = 1; k <= 24; k++) begin
      term = ((term * zarg) >> 31) / 64'(k);
      if (k[0]) odd_sum = odd_sum + term;
      else even_sum = even_sum + term;
    end
    ex = (even_sum > odd_sum) ? even_sum - odd_sum : 64'd0;
    return (64'd11675 * ex) >> (64'd31 + expo_int);
  endfunction

  task automatic model_word(input logic t, input logic c, input logic [9:0] ka,
                            input logic [9:0] kb);
    int unsigned knob;
    int unsigned divisor;
    int unsigned span;
    int unsigned pos;
    int unsigned choice;
    bit          hit;
    quant_word_t w;
    knob = 32'(ka) + 32'(kb);
    if (knob > 1023) knob = 1023;
    if (t && tick_count < COUNT_LIMIT) tick_count++;
    if (!clock_prev && c) begin
      period_old = period_new;
      period_new = tick_count;
      tick_count = 0;
    end
    clock_prev = c;
    w.led = c;
    if (tick_count < timeout_ms) begin
      w.free_flag = 1'b0;
      w.level = LEVEL_MAX;
      divisor = 1 + knob * 5 / 1023;
      span = ((period_new + period_old) / 2) / divisor;
      if (span > glitch_lim) begin
        choice = 255;
        hit = 1'b0;
        for (pos = 0; pos < 256 && !hit; pos++) begin
          if (decay_table[pos] > span && span >= decay_table[pos + 1]) begin
            hit = 1'b1;
            choice = (decay_table[pos] - span <= span - decay_table[pos + 1]) ?
                     pos + 1 : pos;
          end
        end
        if (choice < level_floor) choice = level_floor;
        if (choice > 255) choice = 255;
        w.level = choice[7:0];
      end
    end else begin
      w.free_flag = 1'b1;
      w.level = 8'(1 + knob * 254 / 1023);
    end
    expected_q.push_back(w);
  endtask

  task automatic send_word(input logic t, input logic c, input logic [9:0] ka,
                           input logic [9:0] kb);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    tick <= t;
    clock_level <= c;
    knob_a <= ka;
    knob_b <= kb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_word(t, c, ka, kb);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_regs(input int unsigned tmo, input int unsigned glt,
                          input int unsigned flr);
    cfg_write <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data <= tmo[14:0];
    @(posedge clk);
    cfg_index <= CFG_GLITCH;
    cfg_data <= glt[14:0];
    @(posedge clk);
    cfg_index <= CFG_MIN_LEVEL;
    cfg_data <= CFG_W'(flr[7:0]);
    @(posedge clk);
    cfg_write <= 1'b0;
    timeout_ms = tmo & 32'h7FFF;
    glitch_lim = glt & 32'h7FFF;
    level_floor = flr & 32'hFF;
  endtask

  function automatic logic [9:0] pick_knob();
    case ($urandom_range(9))
      0: return 10'd0;
      1: return 10'h3FF;
      2: return 10'd1;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_word(1'b0, 1'b0, 10'd0, 10'd0);
    send_word(1'b1, 1'b1, 10'd0, 10'd0);
    wait_results_drained();
  endtask

  // With a zero timeout the block never leaves free mode.
  task automatic test_free_knob_map();
    set_regs(0, 80, 5);
    send_word(1'b0, 1'b0, 10'd0, 10'd0);
    send_word(1'b1, 1'b1, 10'h3FF, 10'd0);
    send_word(1'b0, 1'b1, 10'h3FF, 10'h3FF);
    send_word(1'b1, 1'b0, 10'd511, 10'd512);
    send_word(1'b0, 1'b0, 10'd0, 10'd5);
    send_word(1'b1, 1'b1, 10'd1, 10'd0);
    wait_results_drained();
  endtask

  task automatic test_short_periods();
    set_regs(32767, 0, 0);
    send_word(1'b0, 1'b0, 10'd0, 10'd0);
    send_word(1'b1, 1'b1, 10'd0, 10'd0);
    send_word(1'b1, 1'b0, 10'd0, 10'd0);
    send_word(1'b1, 1'b0, 10'd0, 10'd0);
    send_word(1'b1, 1'b1, 10'd0, 10'd0);
    send_word(1'b0, 1'b1, 10'h3FF, 10'h3FF);
    send_word(1'b0, 1'b0, 10'd512, 10'd0);
    send_word(1'b1, 1'b1, 10'd0, 10'd0);
    wait_results_drained();
  endtask

  task automatic test_glitch_ceiling();
    set_regs(32767, 32767, 255);
    send_word(1'b1, 1'b0, 10'd0, 10'd0);
    send_word(1'b1, 1'b1, 10'd0, 10'd0);
    send_word(1'b0, 1'b0, 10'h3FF, 10'd0);
    wait_results_drained();
  endtask

  // Long tick runs in free mode followed by clock edges give long periods,
  // which land on the low entries of the table.
  task automatic test_long_periods();
    int unsigned lens [6] = '{240, 120, 60, 30, 12, 4};
    int unsigned s;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    set_regs(1, 0, 0);
    for (s = 0; s < 6; s++) begin
      if (s == 3) begin
        wait_results_drained();
        set_regs(1, 1500, 9);
      end
      repeat (lens[s]) send_word(1'b1, 1'b0, pick_knob(), pick_knob());
      repeat (6) send_word(1'b0, 1'b1, pick_knob(), pick_knob());
    end
    send_word(1'b0, 1'b0, pick_knob(), pick_knob());
    send_word(1'b0, 1'b1, pick_knob(), pick_knob());
    wait_results_drained();
  endtask

  task automatic random_regs();
    int unsigned tmo;
    int unsigned glt;
    int unsigned flr;
    case ($urandom_range(9))
      0: tmo = 0;
      1: tmo = 1;
      2: tmo = 32767;
      default: tmo = $urandom_range(400, 20);
    endcase
    case ($urandom_range(9))
      0: glt = 0;
      1: glt = 32767;
      2, 3, 4: glt = $urandom_range(30);
      default: glt = $urandom_range(120);
    endcase
    case ($urandom_range(9))
      0: flr = 0;
      1: flr = 255;
      2: flr = $urandom_range(255);
      default: flr = $urandom_range(40);
    endcase
    set_regs(tmo, glt, flr);
  endtask

  task automatic run_random_phase(input int unsigned gap_pct, input int unsigned stall_pct);
    int unsigned sent;
    int unsigned next_cfg;
    int unsigned period;
    int unsigned high_len;
    int unsigned tick_pct;
    int unsigned len;
    int unsigned n;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    next_cfg = 0;
    while (sent < PHASE_WORDS) begin
      if (sent >= next_cfg) begin
        wait_results_drained();
        random_regs();
        next_cfg = next_cfg + 180;
      end else if ($urandom_range(49) == 0) begin
        wait_results_drained();
      end
      if ($urandom_range(99) < 80) begin
        period = ($urandom_range(9) == 0) ? $urandom_range(400, 161) :
                 $urandom_range(160, 2);
        high_len = $urandom_range(period - 1, 1);
        tick_pct = ($urandom_range(1) == 0) ? 100 : $urandom_range(100, 50);
        for (n = 0; n < period; n++) begin
          send_word($urandom_range(99) < tick_pct, n < high_len, pick_knob(),
                    pick_knob());
        end
        sent = sent + period;
      end else begin
        len = $urandom_range(8, 1);
        repeat (len) begin
          send_word(1'($urandom_range(1)), 1'($urandom_range(1)), 10'($urandom),
                    10'($urandom));
        end
        sent = sent + len;
      end
    end
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    run_random_phase(21, 48);
    run_random_phase(48, 21);
    run_random_phase(0, 0);
  endtask

  always @(posedge clk) begin : check_results
    quant_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected word: drive_level %0d free_mode %0b led %0b",
                   $time, drive_level, free_mode, led);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (drive_level !== want.level) begin
            $display("%0t drive_level expected %0d actual %0d", $time, want.level,
                     drive_level);
            errors++;
          end
          if (free_mode !== want.free_flag) begin
            $display("%0t free_mode expected %0b actual %0b", $time, want.free_flag,
                     free_mode);
            errors++;
          end
          if (led !== want.led) begin
            $display("%0t led expected %0b actual %0b", $time, want.led, led);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned slot;
    decay_table[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    for (slot = 1; slot < 256; slot++) decay_table[slot] = decay_entry(slot);
    decay_table[256] = 64'd0;
    timeout_ms = 32'(TIMEOUT_RESET);
    glitch_lim = 32'(GLITCH_RESET);
    level_floor = 32'(MIN_LEVEL_RESET);
    tick_count = 0;
    period_new = 0;
    period_old = 0;
    clock_prev = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_free_knob_map();
    test_short_periods();
    test_glitch_ceiling();
    test_long_periods();
    test_random_traffic();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
